@@ hdl/rpc_pkg.sv @@
package rpc_pkg;

    localparam int NUM_CHANNELS_DEFAULT = 3;
    localparam int MAX_CHANNELS         = 3;

    localparam int TIME_W    = 32;
    localparam int WIDTH_W   = 16;
    localparam int CHAN_W    = 2;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 32;

    localparam logic [WIDTH_W-1:0]      RESET_NO_VALUE    = 16'd0;
    localparam logic [TIME_W-1:0]       RESET_TIMEOUT_US  = 32'd70000;
    localparam logic [WIDTH_W-1:0]      RESET_INTERVAL_MS = 16'd20;
    localparam logic [MAX_CHANNELS-1:0] RESET_ENABLE      = 3'b111;

    localparam logic CMD_EDGE  = 1'b0;
    localparam logic CMD_CHECK = 1'b1;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_NO_VALUE_CODE     = 2'd0,
        REG_LOSS_TIMEOUT_US   = 2'd1,
        REG_CHECK_INTERVAL_MS = 2'd2,
        REG_CHANNEL_ENABLE    = 2'd3
    } cfg_reg_t;

    typedef struct packed {
        logic [WIDTH_W-1:0]      no_value_code;
        logic [TIME_W-1:0]       loss_timeout_us;
        logic [WIDTH_W-1:0]      check_interval_ms;
        logic [MAX_CHANNELS-1:0] channel_enable;
    } cfg_t;

    typedef struct packed {
        logic              cmd;
        logic [CHAN_W-1:0] channel;
        logic              level;
        logic [TIME_W-1:0] now_us;
        logic [TIME_W-1:0] now_ms;
    } item_t;

endpackage

@@ hdl/rpc_if.sv @@
interface rpc_item_if;
    logic                             valid;
    logic                             ready;
    logic                             cmd;
    logic [rpc_pkg::CHAN_W-1:0]       channel;
    logic                             level;
    logic [rpc_pkg::TIME_W-1:0]       now_us;
    logic [rpc_pkg::TIME_W-1:0]       now_ms;

    modport source (output valid, cmd, channel, level, now_us, now_ms, input ready);
    modport sink   (input valid, cmd, channel, level, now_us, now_ms, output ready);
endinterface

interface rpc_result_if;
    logic                             valid;
    logic                             ready;
    logic [rpc_pkg::WIDTH_W-1:0]      throttle_width;
    logic [rpc_pkg::WIDTH_W-1:0]      steering_width;
    logic [rpc_pkg::WIDTH_W-1:0]      aux_width;
    logic                             signal_valid;

    modport source (output valid, throttle_width, steering_width, aux_width, signal_valid,
                    input ready);
    modport sink   (input valid, throttle_width, steering_width, aux_width, signal_valid,
                    output ready);
endinterface

@@ hdl/rpc_cfg_regs.sv @@
module rpc_cfg_regs
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               wr_en,
    input  logic [rpc_pkg::CFG_IDX_W-1:0]      index,
    input  logic [rpc_pkg::CFG_DATA_W-1:0]     wdata,
    output rpc_pkg::cfg_t                      cfg
);

    rpc_pkg::cfg_t cfg_reg;
    rpc_pkg::cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (rpc_pkg::cfg_reg_t'(index))
                rpc_pkg::REG_NO_VALUE_CODE:
                    cfg_next.no_value_code = wdata[rpc_pkg::WIDTH_W-1:0];
                rpc_pkg::REG_LOSS_TIMEOUT_US:
                    cfg_next.loss_timeout_us = wdata[rpc_pkg::TIME_W-1:0];
                rpc_pkg::REG_CHECK_INTERVAL_MS:
                    cfg_next.check_interval_ms = wdata[rpc_pkg::WIDTH_W-1:0];
                rpc_pkg::REG_CHANNEL_ENABLE:
                    cfg_next.channel_enable = wdata[rpc_pkg::MAX_CHANNELS-1:0];
                default:
                    cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.no_value_code     <= rpc_pkg::RESET_NO_VALUE;
            cfg_reg.loss_timeout_us   <= rpc_pkg::RESET_TIMEOUT_US;
            cfg_reg.check_interval_ms <= rpc_pkg::RESET_INTERVAL_MS;
            cfg_reg.channel_enable    <= rpc_pkg::RESET_ENABLE;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

@@ hdl/rpc_in_stage.sv @@
module rpc_in_stage
(
    input  logic            clk,
    input  logic            rst_n,
    rpc_item_if.sink        item,
    input  logic            advance,
    output logic            stage_valid,
    output rpc_pkg::item_t  stage_item
);

    logic           valid_reg;
    logic           valid_next;
    rpc_pkg::item_t item_reg;
    logic           take;

    // Hold the request while the core is stalled.
    assign item.ready = !valid_reg || advance;
    assign take       = item.valid && item.ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (take)
        begin
            valid_next = 1'b1;
        end
        else if (advance)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            item_reg.cmd     <= item.cmd;
            item_reg.channel <= item.channel;
            item_reg.level   <= item.level;
            item_reg.now_us  <= item.now_us;
            item_reg.now_ms  <= item.now_ms;
        end
    end

    assign stage_valid = valid_reg;
    assign stage_item  = item_reg;

endmodule

@@ hdl/rpc_core.sv @@
module rpc_core
#(
    parameter int NUM_CHANNELS = rpc_pkg::NUM_CHANNELS_DEFAULT
)
(
    input  logic            clk,
    input  logic            rst_n,
    input  rpc_pkg::cfg_t   cfg,
    input  logic            stage_valid,
    input  rpc_pkg::item_t  stage_item,
    output logic            advance,
    rpc_result_if.source    result
);

    localparam int TW = rpc_pkg::TIME_W;
    localparam int WW = rpc_pkg::WIDTH_W;

    logic [TW-1:0] start_reg [NUM_CHANNELS];
    logic [TW-1:0] start_next [NUM_CHANNELS];
    logic [WW-1:0] width_reg [NUM_CHANNELS];
    logic [WW-1:0] width_next [NUM_CHANNELS];
    logic [TW-1:0] heartbeat_reg;
    logic [TW-1:0] heartbeat_next;
    logic [TW-1:0] last_check_reg;
    logic [TW-1:0] last_check_next;
    logic          flag_reg;
    logic          flag_next;

    logic          out_valid_reg;
    logic          out_valid_next;
    logic [WW-1:0] out_width_reg [rpc_pkg::MAX_CHANNELS];
    logic [WW-1:0] out_width_next [rpc_pkg::MAX_CHANNELS];
    logic          out_flag_reg;

    logic          fire;
    logic          is_edge;
    logic          check_run;
    logic          lost;
    logic [TW-1:0] elapsed_ms;
    logic [TW-1:0] hb_age;

    assign advance = !out_valid_reg || result.ready;
    assign fire    = stage_valid && advance;
    assign is_edge = (stage_item.cmd == rpc_pkg::CMD_EDGE);

    assign elapsed_ms = stage_item.now_ms - last_check_reg;
    assign hb_age     = stage_item.now_us - heartbeat_reg;
    assign check_run  = !is_edge && (elapsed_ms > {{(TW-WW){1'b0}}, cfg.check_interval_ms});
    assign flag_next  = check_run ? (hb_age < cfg.loss_timeout_us) : flag_reg;
    assign lost       = check_run && flag_reg && !flag_next;
    assign last_check_next = check_run ? stage_item.now_ms : last_check_reg;

    always_comb
    begin
        heartbeat_next = heartbeat_reg;
        for (int c = 0; c < NUM_CHANNELS; c++)
        begin
            start_next[c] = start_reg[c];
            width_next[c] = width_reg[c];
            if (is_edge && stage_item.channel == rpc_pkg::CHAN_W'(c)
                && cfg.channel_enable[c])
            begin
                // Throttle edges do not count as a sign of life.
                if (c != 0)
                begin
                    heartbeat_next = stage_item.now_us;
                end
                if (stage_item.level)
                begin
                    start_next[c] = stage_item.now_us;
                end
                else
                begin
                    width_next[c] = stage_item.now_us[WW-1:0] - start_reg[c][WW-1:0];
                end
            end
            else if (lost)
            begin
                width_next[c] = cfg.no_value_code;
            end
        end
    end

    for (genvar g = 0; g < rpc_pkg::MAX_CHANNELS; g++)
    begin : g_out
        if (g < NUM_CHANNELS)
        begin : g_used
            assign out_width_next[g] = width_next[g];
        end
        else
        begin : g_unused
            assign out_width_next[g] = '0;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (advance)
        begin
            out_valid_next = stage_valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int c = 0; c < NUM_CHANNELS; c++)
            begin
                start_reg[c] <= '0;
                width_reg[c] <= '0;
            end
            heartbeat_reg  <= '0;
            last_check_reg <= '0;
            flag_reg       <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (fire)
            begin
                for (int c = 0; c < NUM_CHANNELS; c++)
                begin
                    start_reg[c] <= start_next[c];
                    width_reg[c] <= width_next[c];
                end
                heartbeat_reg  <= heartbeat_next;
                last_check_reg <= last_check_next;
                flag_reg       <= flag_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            for (int c = 0; c < rpc_pkg::MAX_CHANNELS; c++)
            begin
                out_width_reg[c] <= out_width_next[c];
            end
            out_flag_reg <= flag_next;
        end
    end

    assign result.valid          = out_valid_reg;
    assign result.throttle_width = out_width_reg[0];
    assign result.steering_width = out_width_reg[1];
    assign result.aux_width      = out_width_reg[2];
    assign result.signal_valid   = out_flag_reg;

endmodule

@@ hdl/rc_pwm_pulse_capture.sv @@
// Channel    Dir   Handshake      Payload
// item       in    valid/ready    cmd, channel, level, now_us, now_ms
// result     out   valid/ready    throttle_width, steering_width, aux_width, signal_valid
// cfg        in    cfg_wr_en      cfg_index, cfg_wdata
//
// One request per cycle sustained while the result side is ready. A taken request is
// held in the input register; the result register loads from it when the core
// advances, and the result is offered from there.
// The pulse/heartbeat state updates in one pass of subtract-and-compare logic.
// rst_n clears all timing state, the valid flag and the config registers to defaults.
// A stalled result holds in its register; the input register keeps taking requests
// until both registers are full.
module rc_pwm_pulse_capture
#(
    parameter int NUM_CHANNELS = rpc_pkg::NUM_CHANNELS_DEFAULT
)
(
    input  logic                               clk,
    input  logic                               rst_n,
    rpc_item_if.sink                           item,
    rpc_result_if.source                       result,
    input  logic                               cfg_wr_en,
    input  logic [rpc_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [rpc_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

    rpc_pkg::cfg_t  cfg;
    rpc_pkg::item_t stage_item;
    logic           stage_valid;
    logic           advance;

    rpc_cfg_regs u_cfg
    (
        .clk   (clk),
        .rst_n (rst_n),
        .wr_en (cfg_wr_en),
        .index (cfg_index),
        .wdata (cfg_wdata),
        .cfg   (cfg)
    );

    rpc_in_stage u_in
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .item        (item),
        .advance     (advance),
        .stage_valid (stage_valid),
        .stage_item  (stage_item)
    );

    rpc_core #(
        .NUM_CHANNELS (NUM_CHANNELS)
    ) u_core
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg),
        .stage_valid (stage_valid),
        .stage_item  (stage_item),
        .advance     (advance),
        .result      (result)
    );

endmodule

@@ sim/rpc_readout_checker.sv @@
module rpc_readout_checker
#(
    parameter int NUM_CHANNELS = rpc_pkg::NUM_CHANNELS_DEFAULT
)
(
    input  logic                           clk,
    input  logic                           rst_n,
    rpc_item_if                            item,
    rpc_result_if                          result,
    input  logic                           cfg_wr_en,
    input  logic [rpc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [rpc_pkg::CFG_DATA_W-1:0] cfg_wdata,
    output int                             failures,
    output int                             pending
);

    typedef struct packed {
        logic [rpc_pkg::WIDTH_W-1:0] throttle;
        logic [rpc_pkg::WIDTH_W-1:0] steering;
        logic [rpc_pkg::WIDTH_W-1:0] aux;
        logic                        valid;
    } readout_t;

    readout_t                    readouts_due[$];
    rpc_pkg::cfg_t               cfg;
    logic [rpc_pkg::TIME_W-1:0]  start_us [rpc_pkg::MAX_CHANNELS];
    logic [rpc_pkg::WIDTH_W-1:0] width_us [rpc_pkg::MAX_CHANNELS];
    logic [rpc_pkg::TIME_W-1:0]  heartbeat_us;
    logic [rpc_pkg::TIME_W-1:0]  checked_ms;
    logic                        signal_ok;

    task automatic report_mismatch(input string msg);
        $display("%0t checker: %s", $time, msg);
        failures++;
    endtask

    task automatic decode_request(
        input  logic                       cmd,
        input  logic [rpc_pkg::CHAN_W-1:0] chan,
        input  logic                       lvl,
        input  logic [rpc_pkg::TIME_W-1:0] t_us,
        input  logic [rpc_pkg::TIME_W-1:0] t_ms,
        output readout_t                   ro
    );
        logic [rpc_pkg::TIME_W-1:0] span;
        logic                       was_ok;
        int                         c;
        c = int'(chan);
        if (cmd == rpc_pkg::CMD_EDGE)
        begin
            // drop edges on missing or disabled channels
            if (c < NUM_CHANNELS && cfg.channel_enable[c])
            begin
                if (c != 0)
                    heartbeat_us = t_us;
                if (lvl)
                begin
                    start_us[c] = t_us;
                end
                else
                begin
                    span = t_us - start_us[c];
                    width_us[c] = span[rpc_pkg::WIDTH_W-1:0];
                end
            end
        end
        else
        begin
            span = t_ms - checked_ms;
            if (span > {16'd0, cfg.check_interval_ms})
            begin
                checked_ms = t_ms;
                was_ok = signal_ok;
                span = t_us - heartbeat_us;
                signal_ok = (span < cfg.loss_timeout_us);
                if (was_ok && !signal_ok)
                begin
                    for (int k = 0; k < NUM_CHANNELS; k++)
                        width_us[k] = cfg.no_value_code;
                end
            end
        end
        ro.throttle = width_us[0];
        ro.steering = width_us[1];
        ro.aux      = (NUM_CHANNELS > 2) ? width_us[2] : '0;
        ro.valid    = signal_ok;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        readout_t want;
        readout_t got;
        if (!rst_n)
        begin
            cfg.no_value_code     = rpc_pkg::RESET_NO_VALUE;
            cfg.loss_timeout_us   = rpc_pkg::RESET_TIMEOUT_US;
            cfg.check_interval_ms = rpc_pkg::RESET_INTERVAL_MS;
            cfg.channel_enable    = rpc_pkg::RESET_ENABLE;
            for (int k = 0; k < rpc_pkg::MAX_CHANNELS; k++)
            begin
                start_us[k] = '0;
                width_us[k] = '0;
            end
            heartbeat_us = '0;
            checked_ms   = '0;
            signal_ok    = 1'b0;
            readouts_due.delete();
            failures = 0;
            pending  = 0;
        end
        else
        begin
            if (result.valid && result.ready)
            begin
                if (readouts_due.size() == 0)
                begin
                    report_mismatch("result with no request outstanding");
                end
                else
                begin
                    want = readouts_due.pop_front();
                    if (result.throttle_width !== want.throttle)
                        report_mismatch($sformatf("throttle_width got %0d want %0d",
                                                  result.throttle_width, want.throttle));
                    if (result.steering_width !== want.steering)
                        report_mismatch($sformatf("steering_width got %0d want %0d",
                                                  result.steering_width, want.steering));
                    if (result.aux_width !== want.aux)
                        report_mismatch($sformatf("aux_width got %0d want %0d",
                                                  result.aux_width, want.aux));
                    if (result.signal_valid !== want.valid)
                        report_mismatch($sformatf("signal_valid got %0b want %0b",
                                                  result.signal_valid, want.valid));
                end
            end
            if (cfg_wr_en)
            begin
                case (cfg_index)
                    rpc_pkg::REG_NO_VALUE_CODE:
                        cfg.no_value_code = cfg_wdata[rpc_pkg::WIDTH_W-1:0];
                    rpc_pkg::REG_LOSS_TIMEOUT_US:
                        cfg.loss_timeout_us = cfg_wdata[rpc_pkg::TIME_W-1:0];
                    rpc_pkg::REG_CHECK_INTERVAL_MS:
                        cfg.check_interval_ms = cfg_wdata[rpc_pkg::WIDTH_W-1:0];
                    rpc_pkg::REG_CHANNEL_ENABLE:
                        cfg.channel_enable = cfg_wdata[rpc_pkg::MAX_CHANNELS-1:0];
                    default: ;
                endcase
            end
            if (item.valid && item.ready)
            begin
                decode_request(item.cmd, item.channel, item.level, item.now_us, item.now_ms,
                               got);
                readouts_due.push_back(got);
            end
            pending = readouts_due.size();
        end
    end

endmodule

@@ sim/tb_top.sv @@
module tb_top;

    localparam int N_CH = rpc_pkg::NUM_CHANNELS_DEFAULT;

    logic                           clk;
    logic                           rst_n;
    logic                           cfg_wr_en;
    logic [rpc_pkg::CFG_IDX_W-1:0]  cfg_index;
    logic [rpc_pkg::CFG_DATA_W-1:0] cfg_wdata;
    int                             failures;
    int                             pending;
    int                             sent;
    bit                             calm;
    logic [rpc_pkg::TIME_W-1:0]     t_us;
    logic [rpc_pkg::TIME_W-1:0]     t_ms;
    longint unsigned                us_carry;
    logic [rpc_pkg::TIME_W-1:0]     cur_timeout;
    logic [rpc_pkg::WIDTH_W-1:0]    cur_interval;

    rpc_item_if   item_bus ();
    rpc_result_if result_bus ();

    rc_pwm_pulse_capture #(.NUM_CHANNELS(N_CH)) i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .item      (item_bus),
        .result    (result_bus),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    rpc_readout_checker #(.NUM_CHANNELS(N_CH)) i_checker (
        .clk       (clk),
        .rst_n     (rst_n),
        .item      (item_bus),
        .result    (result_bus),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .failures  (failures),
        .pending   (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #2_000_000;
        $display("** rc_pwm_pulse_capture: FAILED **");
        $finish;
    end

    // stall the result side at random, except in the calm stretch
    always @(negedge clk)
    begin
        result_bus.ready = calm || ($urandom_range(99) >= 21);
    end

    task automatic send_request(input rpc_pkg::item_t r);
        @(negedge clk);
        if (!calm && $urandom_range(99) < 21)
        begin
            item_bus.valid = 1'b0;
            repeat ($urandom_range(1, 2)) @(negedge clk);
        end
        item_bus.valid   = 1'b1;
        item_bus.cmd     = r.cmd;
        item_bus.channel = r.channel;
        item_bus.level   = r.level;
        item_bus.now_us  = r.now_us;
        item_bus.now_ms  = r.now_ms;
        @(posedge clk);
        while (!item_bus.ready) @(posedge clk);
        sent++;
    endtask

    task automatic send_edge(input logic [rpc_pkg::CHAN_W-1:0] chan, input logic lvl);
        rpc_pkg::item_t r;
        r.cmd     = rpc_pkg::CMD_EDGE;
        r.channel = chan;
        r.level   = lvl;
        r.now_us  = t_us;
        r.now_ms  = t_ms;
        send_request(r);
    endtask

    task automatic send_check(input logic [rpc_pkg::TIME_W-1:0] ms_step);
        rpc_pkg::item_t r;
        t_ms      = t_ms + ms_step;
        r.cmd     = rpc_pkg::CMD_CHECK;
        r.channel = rpc_pkg::CHAN_W'($urandom_range(0, 3));
        r.level   = 1'($urandom_range(0, 1));
        r.now_us  = t_us;
        r.now_ms  = t_ms;
        send_request(r);
    endtask

    // move both timestamps forward together, keeping sub-millisecond carry
    task automatic advance_clock(input logic [rpc_pkg::TIME_W-1:0] dus);
        t_us     = t_us + dus;
        us_carry = us_carry + dus;
        t_ms     = t_ms + rpc_pkg::TIME_W'(us_carry / 1000);
        us_carry = us_carry % 1000;
    endtask

    task automatic write_reg(input rpc_pkg::cfg_reg_t idx,
                             input logic [rpc_pkg::CFG_DATA_W-1:0] data);
        cfg_wr_en = 1'b1;
        cfg_index = idx;
        cfg_wdata = data;
        @(negedge clk);
    endtask

    task automatic write_settings(
        input logic [rpc_pkg::WIDTH_W-1:0]      nv,
        input logic [rpc_pkg::TIME_W-1:0]       to,
        input logic [rpc_pkg::WIDTH_W-1:0]      iv,
        input logic [rpc_pkg::MAX_CHANNELS-1:0] en
    );
        write_reg(rpc_pkg::REG_NO_VALUE_CODE, {16'd0, nv});
        write_reg(rpc_pkg::REG_LOSS_TIMEOUT_US, to);
        write_reg(rpc_pkg::REG_CHECK_INTERVAL_MS, {16'd0, iv});
        write_reg(rpc_pkg::REG_CHANNEL_ENABLE, {29'd0, en});
        cfg_wr_en    = 1'b0;
        cur_timeout  = to;
        cur_interval = iv;
    endtask

    // drop valid and drain every outstanding result, then let the pipe empty
    task automatic settle();
        @(negedge clk);
        item_bus.valid = 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic run_traffic(input int n);
        int             goal;
        int             pick;
        rpc_pkg::item_t r;
        goal = sent + n;
        while (sent < goal)
        begin
            pick = $urandom_range(99);
            if (pick < 3)
            begin
                // jump close to the wrap of both timestamps
                t_us = 32'hFFFF_FFFF - $urandom_range(0, 3000);
                t_ms = 32'hFFFF_FFFF - $urandom_range(0, 40);
            end
            else if (pick < 55)
            begin
                // full frame: a pulse on each channel, then a check
                for (int c = 0; c < 3; c++)
                begin
                    advance_clock($urandom_range(20, 400));
                    send_edge(rpc_pkg::CHAN_W'(c), 1'b1);
                    advance_clock(($urandom_range(9) == 0) ? $urandom_range(0, 70000)
                                                           : $urandom_range(900, 2100));
                    send_edge(rpc_pkg::CHAN_W'(c), 1'b0);
                end
                send_check({16'd0, cur_interval} + 32'd1 + $urandom_range(0, 3));
            end
            else if (pick < 70)
            begin
                advance_clock($urandom_range(0, 2000));
                send_check($urandom_range(1) ? {16'd0, cur_interval} + 32'd1
                                             : $urandom_range(0, {16'd0, cur_interval}));
            end
            else if (pick < 80)
            begin
                // radio silence long enough to lose the signal
                advance_clock(cur_timeout + $urandom_range(0, 5000));
                send_check({16'd0, cur_interval} + 32'd1 + $urandom_range(0, 3));
            end
            else if (pick < 90)
            begin
                advance_clock($urandom_range(0, 3000));
                send_edge(rpc_pkg::CHAN_W'($urandom_range(0, 3)), 1'($urandom_range(0, 1)));
            end
            else
            begin
                r.cmd     = 1'($urandom_range(0, 1));
                r.channel = rpc_pkg::CHAN_W'($urandom_range(0, 3));
                r.level   = 1'($urandom_range(0, 1));
                r.now_us  = $urandom;
                r.now_ms  = $urandom;
                send_request(r);
            end
        end
    endtask

    initial
    begin
        rst_n              = 1'b0;
        cfg_wr_en          = 1'b0;
        cfg_index          = '0;
        cfg_wdata          = '0;
        item_bus.valid     = 1'b0;
        item_bus.cmd       = rpc_pkg::CMD_EDGE;
        item_bus.channel   = '0;
        item_bus.level     = 1'b0;
        item_bus.now_us    = '0;
        item_bus.now_ms    = '0;
        sent               = 0;
        calm               = 1'b0;
        t_us               = '0;
        t_ms               = '0;
        us_carry           = 0;
        cur_timeout        = rpc_pkg::RESET_TIMEOUT_US;
        cur_interval       = rpc_pkg::RESET_INTERVAL_MS;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        write_reg(rpc_pkg::REG_NO_VALUE_CODE, 32'h0000_5A5A);
        cfg_wr_en = 1'b0;

        send_check(32'd0);                  // too soon after reset
        t_us = 32'd100;
        send_edge(2'd1, 1'b1);
        send_edge(2'd1, 1'b0);              // zero width
        t_us = 32'd200;
        send_edge(2'd0, 1'b1);
        t_us = 32'd200 + 32'd65535;
        send_edge(2'd0, 1'b0);              // widest pulse
        t_us = 32'hFFFF_FF00;
        send_edge(2'd2, 1'b1);
        t_us = 32'h0000_0100;
        send_edge(2'd2, 1'b0);              // pulse across the wrap
        t_us = 32'h0000_010A;
        send_check(32'd21);                 // signal comes up
        send_edge(2'd3, 1'b1);              // no such channel
        send_check(32'd9);                  // too soon
        t_us = t_us + 32'd80000;
        send_edge(2'd0, 1'b1);
        t_us = t_us + 32'd1500;
        send_edge(2'd0, 1'b0);              // throttle leaves heartbeat stale
        send_check(32'd12);                 // signal lost, widths forced
        send_check(32'd21);                 // stays lost
        t_us = t_us + 32'd10;
        send_edge(2'd1, 1'b1);
        send_check(32'd21);                 // comes back, widths kept
        t_ms = 32'hFFFF_FFF0;
        send_check(32'd0);
        send_check(32'd32);                 // interval across the ms wrap
        settle();

        t_us = $urandom;
        t_ms = $urandom;
        calm = 1'b1;
        write_settings(16'hFFFF, rpc_pkg::RESET_TIMEOUT_US, rpc_pkg::RESET_INTERVAL_MS,
                       3'b111);
        run_traffic(92);
        settle();
        calm = 1'b0;

        write_settings(16'h0000, 32'd1, 16'd0, 3'b000);
        run_traffic(92);
        settle();

        write_settings(rpc_pkg::WIDTH_W'($urandom_range(0, 65535)), 32'hFFFF_FFFF,
                       16'hFFFF, 3'b101);
        run_traffic(92);
        settle();

        write_settings(rpc_pkg::WIDTH_W'($urandom_range(0, 65535)), 32'd5000, 16'd3,
                       3'b110);
        run_traffic(92);
        settle();

        write_settings(rpc_pkg::WIDTH_W'($urandom_range(0, 65535)),
                       $urandom_range(1000, 100000),
                       rpc_pkg::WIDTH_W'($urandom_range(0, 50)),
                       rpc_pkg::MAX_CHANNELS'($urandom_range(0, 7)));
        run_traffic(92);
        settle();

        write_settings(rpc_pkg::WIDTH_W'($urandom_range(0, 65535)),
                       rpc_pkg::RESET_TIMEOUT_US, rpc_pkg::RESET_INTERVAL_MS, 3'b111);
        run_traffic(92);
        settle();

        if (failures == 0)
            $display("** rc_pwm_pulse_capture: PASSED **");
        else
            $display("** rc_pwm_pulse_capture: FAILED **");
        $finish;
    end

endmodule
